// ----- hw/rtl/ica_pkg.sv -----
// Shared constants, widths and the arctangent table for the attitude unit.
// Used by ica_div, ica_sqrt and imu_complementary_attitude_unit; no dependencies.
`default_nettype none

package ica_pkg;

    localparam int VEC_FRAC        = 14;
    localparam int VEC_W           = 16;
    localparam int ANG_W           = 18;
    localparam int OUT_W           = 16;
    localparam int CFG_IDX_W       = 4;
    localparam int CFG_DATA_W      = 16;
    localparam int WEIGHT_W        = 8;
    localparam int THR_W           = 15;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_W          = 22;
    localparam int TAB_IDX_W       = 5;
    localparam int CW              = 35;
    localparam int ZW              = 28;
    localparam int WORK_SHIFT      = 30 - VEC_FRAC;

    localparam int MUL_W           = 33;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int DIV_W           = 48;
    localparam int DEN_W           = 32;
    localparam int RAD_W           = 64;
    localparam int ROOT_W          = 32;

    localparam logic signed [CW-1:0] KINV_Q30     = CW'(652032875);
    localparam logic signed [ZW-1:0] FULL_TURN    = ZW'(23592960);
    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(11796480);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(5898240);
    localparam logic signed [MUL_W-1:0] GYRO_SCALE = MUL_W'(379502);

    localparam logic signed [VEC_W-1:0] VEC_ONE   = VEC_W'(1 << VEC_FRAC);
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST    = WEIGHT_W'(50);
    localparam logic [THR_W-1:0]    THR_RST       = THR_W'(1638);

    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TILT_THRESHOLD = CFG_IDX_W'(1);

    function automatic logic [ATAN_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ica_div.sv -----
// Bit-serial restoring divider with round-half-away-from-zero quotient.
// Depends on ica_pkg for operand widths.
`default_nettype none

module ica_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic signed [ica_pkg::DIV_W-1:0]  num,
    input  wire logic        [ica_pkg::DEN_W-1:0]  den,
    output logic signed      [ica_pkg::DIV_W-1:0]  quo,
    output logic                                   done
);

    localparam int CNT_W = $clog2(ica_pkg::DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ica_pkg::DIV_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ica_pkg::DEN_W-1:0]     den_reg;
    logic [ica_pkg::DEN_W-1:0]     rem_reg;
    logic [ica_pkg::DIV_W-1:0]     q_reg;
    logic [ica_pkg::DIV_W-1:0]     num_mag;
    logic [ica_pkg::DEN_W:0]       trial;

    assign num_mag = num[ica_pkg::DIV_W-1] ? ica_pkg::DIV_W'(-num) : ica_pkg::DIV_W'(num);
    assign trial   = {rem_reg, q_reg[ica_pkg::DIV_W-1]};
    assign quo     = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign done    = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= num[ica_pkg::DIV_W-1];
                den_reg  <= den;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                q_reg    <= num_mag + ica_pkg::DIV_W'(den >> 1);
            end
            else if (busy_reg)
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_reg <= ica_pkg::DEN_W'(trial - {1'b0, den_reg});
                    q_reg   <= {q_reg[ica_pkg::DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[ica_pkg::DEN_W-1:0];
                    q_reg   <= {q_reg[ica_pkg::DIV_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ica_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle, floor result.
// Depends on ica_pkg for operand widths.
`default_nettype none

module ica_sqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ica_pkg::RAD_W-1:0]   rad,
    output logic      [ica_pkg::ROOT_W-1:0]  root,
    output logic                             done
);

    localparam int CNT_W = $clog2(ica_pkg::ROOT_W);
    localparam int REM_W = ica_pkg::ROOT_W + 2;
    localparam logic [CNT_W-1:0] LAST = CNT_W'(ica_pkg::ROOT_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [ica_pkg::RAD_W-1:0]     rad_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [ica_pkg::ROOT_W-1:0]    root_reg;
    logic [REM_W+1:0]              rem_sh;
    logic [REM_W+1:0]              trial;

    assign rem_sh = {rem_reg, rad_reg[ica_pkg::RAD_W-1 -: 2]};
    assign trial  = (REM_W+2)'({root_reg, 2'b01});
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rad_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                rad_reg  <= rad;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (rem_sh >= trial)
                begin
                    rem_reg  <= REM_W'(rem_sh - trial);
                    root_reg <= {root_reg[ica_pkg::ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= REM_W'(rem_sh);
                    root_reg <= {root_reg[ica_pkg::ROOT_W-2:0], 1'b0};
                end
                rad_reg <= {rad_reg[ica_pkg::RAD_W-3:0], 2'b00};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/imu_complementary_attitude_unit.sv -----
// Top level of the complementary attitude filter: sequencer, CORDIC and shared multiplier.
// Depends on ica_pkg, ica_div and ica_sqrt.
//
//   channel   direction   handshake              carries
//   cfg       in          cfg_valid/cfg_ready    cfg_index, cfg_data
//   in        in          in_valid/in_ready      accel_x/y/z, rate_x/y, interval
//   out       out         out_valid/out_ready    angle_xz, angle_yz, gyro_skipped, accel_invalid
//
// One item at a time; the accelerometer-only path and the gyro path are paced by
// the bit-serial divider (six or eight quotients) and the serial root unit (one or
// four roots). The CORDIC runs CORDIC_STEPS steps per angle, four angles per item
// on the gyro path.
// Reset clears the stored estimate to the vertical unit vector and both angles to zero.
// A result held by out_ready low does not stop acceptance of the next transfer.
`default_nettype none

module imu_complementary_attitude_unit #(
    parameter int CORDIC_STEPS = ica_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ica_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ica_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic signed [15:0]                  accel_x,
    input  wire logic signed [15:0]                  accel_y,
    input  wire logic signed [15:0]                  accel_z,
    input  wire logic signed [15:0]                  rate_x,
    input  wire logic signed [15:0]                  rate_y,
    input  wire logic [15:0]                         interval,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [ica_pkg::OUT_W-1:0]         angle_xz,
    output logic signed [ica_pkg::OUT_W-1:0]         angle_yz,
    output logic                                     gyro_skipped,
    output logic                                     accel_invalid
);

    localparam int CW     = ica_pkg::CW;
    localparam int ZW     = ica_pkg::ZW;
    localparam int MW     = ica_pkg::MUL_W;
    localparam int PW     = ica_pkg::PROD_W;
    localparam int VW     = ica_pkg::VEC_W;
    localparam int AW     = ica_pkg::ANG_W;
    localparam int DW     = ica_pkg::DIV_W;
    localparam int ADV_W  = 36;
    localparam int GSQ_W  = 40;
    localparam int CNT_W  = $clog2(CORDIC_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);

    typedef enum logic [5:0] {
        ST_IDLE, ST_SQ_X, ST_SQ_Y, ST_SQ_Z, ST_SQ_ACC, ST_MAG_GO, ST_MAG_WAIT,
        ST_AT_INIT, ST_AT_STEP, ST_ADV1, ST_ADV2, ST_ADV3,
        ST_SC_INIT, ST_SC_RED, ST_SC_STEP, ST_SC_DONE,
        ST_GP_NUM, ST_GP_T, ST_GP_CB, ST_GP_TT, ST_GP_SUM, ST_GP_SQ, ST_GP_SQW,
        ST_GP_DIV, ST_GP_DIVW,
        ST_GZ1, ST_GZ2, ST_GZ3, ST_GZ_SQ, ST_GZ_SQW,
        ST_NM_DIV, ST_NM_DIVW, ST_BL_MUL, ST_BL_DIV, ST_BL_DIVW, ST_EMIT
    } state_t;

    state_t                         state_reg;
    logic [ica_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [ica_pkg::THR_W-1:0]      thr_reg;

    logic signed [VW-1:0]           acc_reg [3];
    logic signed [15:0]             rate_reg [2];
    logic [15:0]                    dt_reg;
    logic signed [VW-1:0]           est_reg [3];
    logic signed [AW-1:0]           held_reg [2];
    logic signed [AW-1:0]           g_reg [3];

    logic                           skip_reg;
    logic                           invalid_reg;
    logic                           axis_reg;
    logic [1:0]                     k_reg;
    logic [31:0]                    sum_reg;
    logic [15:0]                    mag_reg;
    logic signed [PW-1:0]           p_reg;

    logic signed [CW-1:0]           vx_reg;
    logic signed [CW-1:0]           vy_reg;
    logic signed [ZW-1:0]           vz_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           neg_reg;

    logic signed [MW-1:0]           sin_x_reg;
    logic signed [MW-1:0]           cos_x_reg;
    logic signed [MW-1:0]           sin_y_reg;
    logic signed [MW-1:0]           cos_y_reg;
    logic signed [MW-1:0]           num_reg;
    logic signed [MW-1:0]           t_reg;
    logic [ica_pkg::RAD_W-1:0]      rad_reg;
    logic [ica_pkg::DEN_W-1:0]      den_reg;
    logic signed [GSQ_W-1:0]        gsq_reg;

    logic                           out_valid_reg;
    logic signed [ica_pkg::OUT_W-1:0] angle_xz_reg;
    logic signed [ica_pkg::OUT_W-1:0] angle_yz_reg;
    logic                           skipped_reg;
    logic                           invalid_out_reg;

    logic signed [MW-1:0]           mul_a;
    logic signed [MW-1:0]           mul_b;
    logic signed [MW-1:0]           sa;
    logic signed [MW-1:0]           ca;
    logic signed [MW-1:0]           sb;
    logic signed [MW-1:0]           cb;
    logic signed [MW-1:0]           cb_abs;
    logic signed [CW-1:0]           x_sh;
    logic signed [CW-1:0]           y_sh;
    logic signed [ZW-1:0]           atan_step;
    logic signed [CW-1:0]           at_x0;
    logic signed [CW-1:0]           at_y0;

    logic signed [ZW-1:0]           z_abs;
    logic signed [ZW-1:0]           base_mag;
    logic signed [ADV_W-1:0]        base;
    logic [PW-1:0]                  p_abs;
    logic [PW-1:0]                  p_rnd;
    logic signed [ADV_W-1:0]        delta;
    logic signed [ADV_W-1:0]        adv_sum;
    logic signed [AW-1:0]           adv_held;

    logic signed [GSQ_W-1:0]        gz_rem;
    logic [VW:0]                    est_z_abs;

    logic                           div_start;
    logic signed [DW-1:0]           div_num;
    logic [ica_pkg::DEN_W-1:0]      div_den;
    logic signed [DW-1:0]           div_quo;
    logic                           div_done;
    logic                           sqrt_start;
    logic [ica_pkg::RAD_W-1:0]      sqrt_rad;
    logic [ica_pkg::ROOT_W-1:0]     sqrt_root;
    logic                           sqrt_done;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign angle_xz      = angle_xz_reg;
    assign angle_yz      = angle_yz_reg;
    assign gyro_skipped  = skipped_reg;
    assign accel_invalid = invalid_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= ica_pkg::WEIGHT_RST;
            thr_reg    <= ica_pkg::THR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ica_pkg::REG_GYRO_WEIGHT:    weight_reg <= cfg_data[ica_pkg::WEIGHT_W-1:0];
                ica_pkg::REG_TILT_THRESHOLD: thr_reg    <= cfg_data[ica_pkg::THR_W-1:0];
                default:                     ;
            endcase
        end
    end

    assign sa     = axis_reg ? sin_y_reg : sin_x_reg;
    assign ca     = axis_reg ? cos_y_reg : cos_x_reg;
    assign sb     = axis_reg ? sin_x_reg : sin_y_reg;
    assign cb     = axis_reg ? cos_x_reg : cos_y_reg;
    assign cb_abs = cb[MW-1] ? -cb : cb;

    assign x_sh      = vx_reg >>> cnt_reg;
    assign y_sh      = vy_reg >>> cnt_reg;
    assign atan_step = $signed(ZW'(ica_pkg::atan_tab(ica_pkg::TAB_IDX_W'(cnt_reg))));
    assign at_x0     = CW'(est_reg[2]) <<< ica_pkg::WORK_SHIFT;
    assign at_y0     = CW'(est_reg[axis_reg]) <<< ica_pkg::WORK_SHIFT;

    assign z_abs    = vz_reg[ZW-1] ? -vz_reg : vz_reg;
    assign base_mag = (z_abs + ZW'(256)) >>> 9;
    assign base     = vz_reg[ZW-1] ? -ADV_W'(base_mag) : ADV_W'(base_mag);
    assign p_abs    = p_reg[PW-1] ? PW'(-p_reg) : PW'(p_reg);
    assign p_rnd    = p_abs + (PW'(1) << 31);
    assign delta    = p_reg[PW-1] ? -$signed(ADV_W'(p_rnd[PW-1:32]))
                                  : $signed(ADV_W'(p_rnd[PW-1:32]));
    assign adv_sum  = base + delta;
    assign adv_held = (adv_sum > ADV_W'(131071))  ? AW'(131071) :
                      (adv_sum < -ADV_W'(131072)) ? AW'(-131072) : AW'(adv_sum);

    assign gz_rem    = (GSQ_W'(1) << (2 * ica_pkg::VEC_FRAC)) - gsq_reg - p_reg[GSQ_W-1:0];
    assign est_z_abs = est_reg[2][VW-1] ? (VW+1)'(-(VW+1)'(est_reg[2]))
                                        : (VW+1)'(est_reg[2]);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_SQ_X:
            begin
                mul_a = MW'(acc_reg[0]);
                mul_b = MW'(acc_reg[0]);
            end
            ST_SQ_Y:
            begin
                mul_a = MW'(acc_reg[1]);
                mul_b = MW'(acc_reg[1]);
            end
            ST_SQ_Z:
            begin
                mul_a = MW'(acc_reg[2]);
                mul_b = MW'(acc_reg[2]);
            end
            ST_ADV1:
            begin
                mul_a = MW'(rate_reg[axis_reg]);
                mul_b = $signed(MW'(dt_reg));
            end
            ST_ADV2:
            begin
                mul_a = p_reg[MW-1:0];
                mul_b = ica_pkg::GYRO_SCALE;
            end
            ST_GP_NUM:
            begin
                mul_a = sa;
                mul_b = cb_abs;
            end
            ST_GP_T:
            begin
                mul_a = ca;
                mul_b = sb;
            end
            ST_GP_CB:
            begin
                mul_a = cb;
                mul_b = cb;
            end
            ST_GP_TT:
            begin
                mul_a = t_reg;
                mul_b = t_reg;
            end
            ST_GZ1:
            begin
                mul_a = MW'(g_reg[0]);
                mul_b = MW'(g_reg[0]);
            end
            ST_GZ2:
            begin
                mul_a = MW'(g_reg[1]);
                mul_b = MW'(g_reg[1]);
            end
            ST_BL_MUL:
            begin
                mul_a = $signed(MW'(weight_reg));
                mul_b = MW'(g_reg[k_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            ST_GP_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'(num_reg) <<< ica_pkg::VEC_FRAC;
                div_den   = den_reg;
            end
            ST_NM_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'(acc_reg[k_reg]) <<< ica_pkg::VEC_FRAC;
                div_den   = ica_pkg::DEN_W'(mag_reg);
            end
            ST_BL_DIV:
            begin
                div_start = 1'b1;
                div_num   = DW'(num_reg) + p_reg[DW-1:0];
                div_den   = ica_pkg::DEN_W'(weight_reg) + 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == ST_MAG_GO) || (state_reg == ST_GP_SQ) ||
                        (state_reg == ST_GZ_SQ);
    assign sqrt_rad   = (state_reg == ST_MAG_GO) ? ica_pkg::RAD_W'(sum_reg) : rad_reg;

    ica_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .done  (div_done)
    );

    ica_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .rad   (sqrt_rad),
        .root  (sqrt_root),
        .done  (sqrt_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            est_reg[0]      <= '0;
            est_reg[1]      <= '0;
            est_reg[2]      <= ica_pkg::VEC_ONE;
            held_reg[0]     <= '0;
            held_reg[1]     <= '0;
            g_reg[0]        <= '0;
            g_reg[1]        <= '0;
            g_reg[2]        <= '0;
            acc_reg[0]      <= '0;
            acc_reg[1]      <= '0;
            acc_reg[2]      <= '0;
            rate_reg[0]     <= '0;
            rate_reg[1]     <= '0;
            dt_reg          <= '0;
            skip_reg        <= 1'b0;
            invalid_reg     <= 1'b0;
            axis_reg        <= 1'b0;
            k_reg           <= '0;
            sum_reg         <= '0;
            mag_reg         <= '0;
            p_reg           <= '0;
            vx_reg          <= '0;
            vy_reg          <= '0;
            vz_reg          <= '0;
            cnt_reg         <= '0;
            neg_reg         <= 1'b0;
            sin_x_reg       <= '0;
            cos_x_reg       <= '0;
            sin_y_reg       <= '0;
            cos_y_reg       <= '0;
            num_reg         <= '0;
            t_reg           <= '0;
            rad_reg         <= '0;
            den_reg         <= '0;
            gsq_reg         <= '0;
            out_valid_reg   <= 1'b0;
            angle_xz_reg    <= '0;
            angle_yz_reg    <= '0;
            skipped_reg     <= 1'b0;
            invalid_out_reg <= 1'b0;
        end
        else
        begin
            p_reg <= mul_a * mul_b;
            if (out_valid_reg && out_ready && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        acc_reg[0]  <= accel_x;
                        acc_reg[1]  <= accel_y;
                        acc_reg[2]  <= accel_z;
                        rate_reg[0] <= rate_x;
                        rate_reg[1] <= rate_y;
                        dt_reg      <= interval;
                        skip_reg    <= est_z_abs < (VW+1)'(thr_reg);
                        sum_reg     <= '0;
                        state_reg   <= ST_SQ_X;
                    end
                end
                ST_SQ_X:
                begin
                    state_reg <= ST_SQ_Y;
                end
                ST_SQ_Y:
                begin
                    sum_reg   <= sum_reg + p_reg[31:0];
                    state_reg <= ST_SQ_Z;
                end
                ST_SQ_Z:
                begin
                    sum_reg   <= sum_reg + p_reg[31:0];
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    sum_reg   <= sum_reg + p_reg[31:0];
                    state_reg <= ST_MAG_GO;
                end
                ST_MAG_GO:
                begin
                    state_reg <= ST_MAG_WAIT;
                end
                ST_MAG_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        mag_reg     <= sqrt_root[15:0];
                        invalid_reg <= (sqrt_root == '0);
                        axis_reg    <= 1'b0;
                        k_reg       <= '0;
                        if (!skip_reg)
                        begin
                            state_reg <= ST_AT_INIT;
                        end
                        else
                        begin
                            g_reg[0] <= AW'(est_reg[0]);
                            g_reg[1] <= AW'(est_reg[1]);
                            g_reg[2] <= AW'(est_reg[2]);
                            state_reg <= (sqrt_root == '0) ? ST_EMIT : ST_NM_DIV;
                        end
                    end
                end
                ST_AT_INIT:
                begin
                    cnt_reg <= '0;
                    if (at_x0 == '0 && at_y0 == '0)
                    begin
                        vz_reg    <= '0;
                        state_reg <= ST_ADV1;
                    end
                    else if (at_x0 < 0)
                    begin
                        vz_reg    <= (at_y0 >= 0) ? ica_pkg::HALF_TURN : -ica_pkg::HALF_TURN;
                        vx_reg    <= -at_x0;
                        vy_reg    <= -at_y0;
                        state_reg <= ST_AT_STEP;
                    end
                    else
                    begin
                        vz_reg    <= '0;
                        vx_reg    <= at_x0;
                        vy_reg    <= at_y0;
                        state_reg <= ST_AT_STEP;
                    end
                end
                ST_AT_STEP:
                begin
                    if (vy_reg > 0)
                    begin
                        vx_reg <= vx_reg + y_sh;
                        vy_reg <= vy_reg - x_sh;
                        vz_reg <= vz_reg + atan_step;
                    end
                    else
                    begin
                        vx_reg <= vx_reg - y_sh;
                        vy_reg <= vy_reg + x_sh;
                        vz_reg <= vz_reg - atan_step;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_ADV1;
                    end
                end
                ST_ADV1:
                begin
                    state_reg <= ST_ADV2;
                end
                ST_ADV2:
                begin
                    state_reg <= ST_ADV3;
                end
                ST_ADV3:
                begin
                    held_reg[axis_reg] <= adv_held;
                    state_reg          <= ST_SC_INIT;
                end
                ST_SC_INIT:
                begin
                    vz_reg    <= ZW'(held_reg[axis_reg]) <<< 9;
                    neg_reg   <= 1'b0;
                    state_reg <= ST_SC_RED;
                end
                ST_SC_RED:
                begin
                    if (vz_reg >= ica_pkg::HALF_TURN)
                    begin
                        vz_reg <= vz_reg - ica_pkg::FULL_TURN;
                    end
                    else if (vz_reg < -ica_pkg::HALF_TURN)
                    begin
                        vz_reg <= vz_reg + ica_pkg::FULL_TURN;
                    end
                    else
                    begin
                        if (vz_reg > ica_pkg::QUARTER_TURN)
                        begin
                            vz_reg  <= vz_reg - ica_pkg::HALF_TURN;
                            neg_reg <= 1'b1;
                        end
                        else if (vz_reg < -ica_pkg::QUARTER_TURN)
                        begin
                            vz_reg  <= vz_reg + ica_pkg::HALF_TURN;
                            neg_reg <= 1'b1;
                        end
                        vx_reg    <= ica_pkg::KINV_Q30;
                        vy_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_SC_STEP;
                    end
                end
                ST_SC_STEP:
                begin
                    if (vz_reg >= 0)
                    begin
                        vx_reg <= vx_reg - y_sh;
                        vy_reg <= vy_reg + x_sh;
                        vz_reg <= vz_reg - atan_step;
                    end
                    else
                    begin
                        vx_reg <= vx_reg + y_sh;
                        vy_reg <= vy_reg - x_sh;
                        vz_reg <= vz_reg + atan_step;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_SC_DONE;
                    end
                end
                ST_SC_DONE:
                begin
                    if (!axis_reg)
                    begin
                        sin_x_reg <= neg_reg ? MW'(-vy_reg) : MW'(vy_reg);
                        cos_x_reg <= neg_reg ? MW'(-vx_reg) : MW'(vx_reg);
                        axis_reg  <= 1'b1;
                        state_reg <= ST_AT_INIT;
                    end
                    else
                    begin
                        sin_y_reg <= neg_reg ? MW'(-vy_reg) : MW'(vy_reg);
                        cos_y_reg <= neg_reg ? MW'(-vx_reg) : MW'(vx_reg);
                        axis_reg  <= 1'b0;
                        state_reg <= ST_GP_NUM;
                    end
                end
                ST_GP_NUM:
                begin
                    state_reg <= ST_GP_T;
                end
                ST_GP_T:
                begin
                    num_reg   <= MW'(p_reg >>> 30);
                    state_reg <= ST_GP_CB;
                end
                ST_GP_CB:
                begin
                    t_reg     <= MW'(p_reg >>> 30);
                    state_reg <= ST_GP_TT;
                end
                ST_GP_TT:
                begin
                    rad_reg   <= p_reg[ica_pkg::RAD_W-1:0];
                    state_reg <= ST_GP_SUM;
                end
                ST_GP_SUM:
                begin
                    rad_reg   <= rad_reg + p_reg[ica_pkg::RAD_W-1:0];
                    state_reg <= ST_GP_SQ;
                end
                ST_GP_SQ:
                begin
                    state_reg <= ST_GP_SQW;
                end
                ST_GP_SQW:
                begin
                    if (sqrt_done)
                    begin
                        den_reg <= sqrt_root;
                        if (sqrt_root == '0)
                        begin
                            g_reg[axis_reg] <= '0;
                            axis_reg        <= 1'b1;
                            state_reg       <= axis_reg ? ST_GZ1 : ST_GP_NUM;
                        end
                        else
                        begin
                            state_reg <= ST_GP_DIV;
                        end
                    end
                end
                ST_GP_DIV:
                begin
                    state_reg <= ST_GP_DIVW;
                end
                ST_GP_DIVW:
                begin
                    if (div_done)
                    begin
                        g_reg[axis_reg] <= AW'(div_quo);
                        axis_reg        <= 1'b1;
                        state_reg       <= axis_reg ? ST_GZ1 : ST_GP_NUM;
                    end
                end
                ST_GZ1:
                begin
                    state_reg <= ST_GZ2;
                end
                ST_GZ2:
                begin
                    gsq_reg   <= p_reg[GSQ_W-1:0];
                    state_reg <= ST_GZ3;
                end
                ST_GZ3:
                begin
                    rad_reg   <= gz_rem[GSQ_W-1] ? '0 : ica_pkg::RAD_W'(gz_rem);
                    state_reg <= ST_GZ_SQ;
                end
                ST_GZ_SQ:
                begin
                    state_reg <= ST_GZ_SQW;
                end
                ST_GZ_SQW:
                begin
                    if (sqrt_done)
                    begin
                        g_reg[2]  <= cos_x_reg[MW-1] ? -$signed(AW'(sqrt_root))
                                                     : $signed(AW'(sqrt_root));
                        k_reg     <= '0;
                        state_reg <= invalid_reg ? ST_EMIT : ST_NM_DIV;
                    end
                end
                ST_NM_DIV:
                begin
                    state_reg <= ST_NM_DIVW;
                end
                ST_NM_DIVW:
                begin
                    if (div_done)
                    begin
                        num_reg   <= MW'(div_quo);
                        state_reg <= ST_BL_MUL;
                    end
                end
                ST_BL_MUL:
                begin
                    state_reg <= ST_BL_DIV;
                end
                ST_BL_DIV:
                begin
                    state_reg <= ST_BL_DIVW;
                end
                ST_BL_DIVW:
                begin
                    if (div_done)
                    begin
                        est_reg[k_reg] <= (div_quo > DW'(32767))  ? VW'(32767) :
                                          (div_quo < -DW'(32768)) ? VW'(-32768) :
                                                                    VW'(div_quo);
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= (k_reg == 2'd2) ? ST_EMIT : ST_NM_DIV;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        angle_xz_reg    <= (held_reg[0] > AW'(32767))  ? 16'sd32767 :
                                           (held_reg[0] < -AW'(32768)) ? -16'sd32768 :
                                                                         16'(held_reg[0]);
                        angle_yz_reg    <= (held_reg[1] > AW'(32767))  ? 16'sd32767 :
                                           (held_reg[1] < -AW'(32768)) ? -16'sd32768 :
                                                                         16'(held_reg[1]);
                        skipped_reg     <= skip_reg;
                        invalid_out_reg <= invalid_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_sqrt_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_MAG_WAIT || state_reg == ST_GP_SQW ||
                       state_reg == ST_GZ_SQW))
        else $error("root unit finished outside a wait state");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_GP_DIVW || state_reg == ST_NM_DIVW ||
                      state_reg == ST_BL_DIVW))
        else $error("divider finished outside a wait state");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised without passing the emit state");

    a_skip_keeps_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAG_WAIT && skip_reg) |=> $stable(held_reg[0]))
        else $error("held angle moved on the accelerometer-only path");

endmodule

`default_nettype wire
